// ===== rtl/core/cvts_pkg.sv =====
// Shared types and constants for the CRT controller vertical timing sequencer.
// No dependencies; used by every file under rtl/core.
`default_nettype none

package cvts_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 14;

  // result bit positions in m_tdata
  localparam int OB_STATUS_LO = 0;
  localparam int OB_DISP_EN   = 4;
  localparam int OB_ROW_LO    = 5;
  localparam int OB_MEM_LO    = 10;
  localparam int OB_CURSOR    = 26;
  localparam int OB_BLINK     = 27;
  localparam int OB_FRAME     = 28;
  localparam int OB_LINE_LO   = 29;
  localparam int OB_LINE_HI   = 37;

  localparam logic [13:0] START_MASK  = 14'h3FFF;
  localparam logic [1:0]  IL_FULL     = 2'b11;
  localparam logic [1:0]  BLINK_OFF   = 2'b01;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HORIZ_DISPLAYED = 3'd0,
    REG_VERT_TOTAL      = 3'd1,
    REG_VERT_ADJUST     = 3'd2,
    REG_VERT_DISPLAYED  = 3'd3,
    REG_VSYNC_ROW       = 3'd4,
    REG_ROW_MODE        = 3'd5,
    REG_CURSOR_ROWS     = 3'd6,
    REG_START_ADDRESS   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  horiz_displayed;
    logic [6:0]  vert_total;
    logic [4:0]  vert_adjust;
    logic [6:0]  vert_displayed;
    logic [6:0]  vsync_row;
    logic [6:0]  row_mode;
    logic [12:0] cursor_rows;
    logic [13:0] start_address;
  } cfg_t;

  typedef struct packed {
    logic        half_phase;
    logic [4:0]  scan_count;
    logic [6:0]  char_row;
    logic [4:0]  adjust_left;
    logic [4:0]  vsync_left;
    logic [15:0] run_address;
    logic [15:0] row_base;
    logic        disp_on;
    logic        cursor_line;
    logic        cursor_allowed;
    logic [4:0]  blink_count;
    logic [3:0]  status_reg;
    logic [8:0]  line_count;
  } state_t;

  // scanline compare; interlace mode 3 also hits at half the target
  function automatic logic row_match(input logic [4:0] sc, input logic [4:0] target,
                                     input logic il);
    return (sc == target) || (il && (sc == {1'b0, target[4:1]}));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cvts_cfg_regs.sv =====
// Configuration register bank for the vertical timing sequencer.
// Depends on cvts_pkg (cfg_t, cfg_idx_t).
`default_nettype none

module cvts_cfg_regs (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              we,
  input  wire  [cvts_pkg::CFG_IDX_W-1:0]   index,
  input  wire  [cvts_pkg::CFG_DATA_W-1:0]  wdata,
  output cvts_pkg::cfg_t                   cfg
);

  cvts_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (we) begin
      unique case (cvts_pkg::cfg_idx_t'(index))
        cvts_pkg::REG_HORIZ_DISPLAYED: regs.horiz_displayed <= wdata[7:0];
        cvts_pkg::REG_VERT_TOTAL:      regs.vert_total      <= wdata[6:0];
        cvts_pkg::REG_VERT_ADJUST:     regs.vert_adjust     <= wdata[4:0];
        cvts_pkg::REG_VERT_DISPLAYED:  regs.vert_displayed  <= wdata[6:0];
        cvts_pkg::REG_VSYNC_ROW:       regs.vsync_row       <= wdata[6:0];
        cvts_pkg::REG_ROW_MODE:        regs.row_mode        <= wdata[6:0];
        cvts_pkg::REG_CURSOR_ROWS:     regs.cursor_rows     <= wdata[12:0];
        cvts_pkg::REG_START_ADDRESS:   regs.start_address   <= wdata[13:0];
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== rtl/core/cvts_timing.sv =====
// Vertical timing state and per-tick next-state logic; produces the packed result.
// Depends on cvts_pkg (cfg_t, state_t, row_match, result bit positions).
`default_nettype none

module cvts_timing #(
  parameter int LINE_WRAP   = 360,
  parameter int VSYNC_LINES = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                accept,
  input  wire                                advance,
  input  cvts_pkg::cfg_t                     cfg,
  output logic [cvts_pkg::OUT_TDATA_W-1:0]   result
);

  cvts_pkg::state_t st, st_next;

  logic        il;
  logic [4:0]  max_sc, cur_start, cur_end;
  logic [6:0]  row_inc;
  logic [4:0]  adj_dec;
  logic [9:0]  line_inc;
  logic [15:0] top_address;
  logic        frame_done;

  assign il          = (cfg.row_mode[6:5] == cvts_pkg::IL_FULL);
  assign max_sc      = cfg.row_mode[4:0];
  assign cur_start   = cfg.cursor_rows[4:0];
  assign cur_end     = cfg.cursor_rows[12:8];
  assign row_inc     = 7'(st.char_row + 7'd1);
  assign adj_dec     = 5'(st.adjust_left - 5'd1);
  assign line_inc    = {1'b0, st.line_count} + 10'd1;
  assign top_address = {2'b00, cfg.start_address & cvts_pkg::START_MASK};

  always_comb begin
    st_next    = st;
    frame_done = 1'b0;
    if (advance) begin
      if (!st.half_phase) begin
        // first half: horizontal retrace begins
        st_next.status_reg[0] = 1'b1;
        st_next.half_phase    = 1'b1;
        if (st.disp_on)
          st_next.run_address = 16'(st.run_address + {8'd0, cfg.horiz_displayed});
        if (st.char_row == cfg.vsync_row && st.scan_count == 5'd0)
          st_next.status_reg[3] = 1'b1;
        if (line_inc >= 10'(LINE_WRAP))
          st_next.line_count = '0;
        else
          st_next.line_count = line_inc[8:0];
      end else begin
        if (st.disp_on)
          st_next.status_reg[0] = 1'b0;
        st_next.half_phase = 1'b0;
        if (st.vsync_left != 5'd0) begin
          st_next.vsync_left = 5'(st.vsync_left - 5'd1);
          if (st.vsync_left == 5'd1)
            st_next.status_reg[3] = 1'b0;
        end
        if (cvts_pkg::row_match(st.scan_count, cur_end, il))
          st_next.cursor_line = 1'b0;
        if (st.adjust_left != 5'd0) begin
          st_next.scan_count  = 5'(st.scan_count + 5'd1);
          st_next.run_address = st.row_base;
          st_next.adjust_left = adj_dec;
          if (adj_dec == 5'd0) begin
            st_next.disp_on     = 1'b1;
            st_next.row_base    = top_address;
            st_next.run_address = top_address;
            st_next.scan_count  = '0;
          end
        end else if (cvts_pkg::row_match(st.scan_count, max_sc, il)) begin
          // end of character row
          st_next.row_base   = st.run_address;
          st_next.scan_count = '0;
          st_next.char_row   = row_inc;
          if (row_inc == cfg.vert_displayed)
            st_next.disp_on = 1'b0;
          if (st.char_row == cfg.vert_total) begin
            st_next.char_row    = '0;
            st_next.adjust_left = cfg.vert_adjust;
            if (cfg.vert_adjust == 5'd0) begin
              st_next.disp_on     = 1'b1;
              st_next.row_base    = top_address;
              st_next.run_address = top_address;
            end
            if (cfg.cursor_rows[6:5] == cvts_pkg::BLINK_OFF)
              st_next.cursor_allowed = 1'b0;
            else
              st_next.cursor_allowed = st.blink_count[4];
          end
          if (st_next.char_row == cfg.vsync_row) begin
            st_next.disp_on     = 1'b0;
            st_next.line_count  = '0;
            st_next.vsync_left  = 5'(VSYNC_LINES);
            frame_done          = (cfg.vsync_row != 7'd0);
            st_next.blink_count = 5'(st.blink_count + 5'd1);
          end
        end else begin
          st_next.scan_count  = 5'(st.scan_count + 5'd1);
          st_next.run_address = st.row_base;
        end
        if (cvts_pkg::row_match(st_next.scan_count, cur_start, il))
          st_next.cursor_line = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // fields from the highest bit down, zero-filled to 40 bits
  assign result = {2'b00,
                   st_next.line_count,
                   frame_done,
                   st_next.blink_count[4],
                   st_next.cursor_line & st_next.cursor_allowed,
                   st_next.run_address,
                   st_next.scan_count,
                   st_next.disp_on,
                   st_next.status_reg};

endmodule

`default_nettype wire

// ===== rtl/core/cvts_out_buf.sv =====
// Two-entry output buffer (output register plus skid register) for result requests.
// Depends on cvts_pkg (OUT_TDATA_W).
`default_nettype none

module cvts_out_buf (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [cvts_pkg::OUT_TDATA_W-1:0]  in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [cvts_pkg::OUT_TDATA_W-1:0]  out_data
);

  logic                             skid_valid;
  logic [cvts_pkg::OUT_TDATA_W-1:0] skid_data;
  logic                             in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crtc_vertical_timing_sequencer_core.sv =====
// Top level of the 6845-style CRT controller vertical timing sequencer.
// Depends on cvts_pkg, cvts_cfg_regs, cvts_timing and cvts_out_buf.
`default_nettype none

// Each request on the s_ side is one tick: advance = 1 steps the vertical timing by
// half a scanline (alternating first half / second half), advance = 0 only reports
// the current state. Every accepted request yields exactly one result request on the
// m_ side carrying status, display enable, scanline, memory address, cursor, blink,
// frame-done and line number as they stand after that tick. One request is taken per
// clock: the tick's next-state logic is a single pass of counters and compares between
// the timing state register and the result buffer, so throughput is one item a cycle
// while s_tready is high. The two-entry result buffer keeps s_tready high while one
// result waits on m_tready; it drops only when both entries are full. Registers,
// written through cfg_we/cfg_index/cfg_wdata, take effect on the next tick; the user
// must write them only while idle (unchecked); all state and registers clear on rst.
module crtc_vertical_timing_sequencer_core #(
  parameter int LINE_WRAP   = 360,
  parameter int VSYNC_LINES = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  // tick requests
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [cvts_pkg::IN_TDATA_W-1:0]   s_tdata,  // [0] advance, [7:1] zero
  // results
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // [3:0] status_bits, [4] display_enable, [9:5] row_address,
  // [25:10] memory_address, [26] cursor_visible, [27] blink_phase,
  // [28] frame_done, [37:29] line_number, [39:38] zero
  output logic [cvts_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // register writes
  input  wire                               cfg_we,
  input  wire  [cvts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [cvts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  cvts_pkg::cfg_t                   cfg;
  logic                             accept;
  logic [cvts_pkg::OUT_TDATA_W-1:0] result;

  // state advances only on an accepted request
  assign accept = s_tvalid && s_tready;

  cvts_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  cvts_timing #(
    .LINE_WRAP   (LINE_WRAP),
    .VSYNC_LINES (VSYNC_LINES)
  ) u_timing (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .advance (s_tdata[0]),
    .cfg     (cfg),
    .result  (result)
  );

  cvts_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cvts_checker.sv =====
// Port-level checks for the vertical timing sequencer, bound to the top level.
// Depends on cvts_pkg (result bit positions) and crtc_vertical_timing_sequencer_core.
`default_nettype none

module cvts_checker #(
  parameter int LINE_WRAP = 360
) (
  input wire                               clk,
  input wire                               rst,
  input wire                               s_tvalid,
  input wire                               s_tready,
  input wire                               m_tvalid,
  input wire                               m_tready,
  input wire [cvts_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // input backpressure only when a result is pending
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |-> m_tvalid)
    else $error("s_tready low with empty output");

  // reaching the vsync row always blanks the display
  a_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[cvts_pkg::OB_FRAME] |-> !m_tdata[cvts_pkg::OB_DISP_EN])
    else $error("frame_done with display enabled");

  // line counter stays below its wrap point
  a_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      m_tdata[cvts_pkg::OB_LINE_HI:cvts_pkg::OB_LINE_LO] < 9'(LINE_WRAP))
    else $error("line_number out of range");

  // reset empties the result buffer
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind crtc_vertical_timing_sequencer_core cvts_checker #(.LINE_WRAP(LINE_WRAP)) u_cvts_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for crtc_vertical_timing_sequencer_core: streams tick requests,
// predicts every result request from its own model of the vertical timing and
// compares field by field. Depends on cvts_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_WRAP   = 360;
  localparam int VSYNC_LINES = 16;
  localparam int CYCLE_LIMIT = 200000;  // watchdog limit for the whole run
  localparam int IDLE_PCT    = 11;      // chance of a gap on either side
  localparam int DRAIN_WAIT  = 4;       // extra wait once all results are back

  // one predicted result request, unpacked
  typedef struct packed {
    logic [3:0]  status;
    logic        disp_en;
    logic [4:0]  row;
    logic [15:0] mem;
    logic        cursor;
    logic        blink;
    logic        frame;
    logic [8:0]  line_no;
  } scan_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [cvts_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [cvts_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             cfg_we = 1'b0;
  cvts_pkg::cfg_idx_t               cfg_index = cvts_pkg::REG_HORIZ_DISPLAYED;
  logic [cvts_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // model of the block: register file and timing state
  cvts_pkg::cfg_t   regs = '0;
  cvts_pkg::state_t tm = '0;

  bit           tick_plan[$];        // advance bits still to be sent
  scan_report_t expected_scans[$];   // predictions waiting for their result

  bit calm = 1'b0;                   // no random gaps on either side while set
  int mismatch_count = 0;
  int results_checked = 0;
  int frames_predicted = 0;
  int settings_used = 0;
  int cycle_count = 0;

  crtc_vertical_timing_sequencer_core #(
    .LINE_WRAP  (LINE_WRAP),
    .VSYNC_LINES(VSYNC_LINES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // scanline compare; with full interlace the half value hits as well
  function automatic logic scan_hit(input logic [4:0] sc, input logic [4:0] tgt,
                                    input logic il);
    return (sc == tgt) || (il && (sc == (tgt >> 1)));
  endfunction

  // frame top: display back on, address reloaded from start register
  function automatic void load_frame_top();
    tm.disp_on     = 1'b1;
    tm.row_base    = {2'b00, regs.start_address & cvts_pkg::START_MASK};
    tm.run_address = tm.row_base;
  endfunction

  // one tick: advance = 0 only reports, else steps half a scanline
  function automatic scan_report_t advance_timing(input logic adv);
    scan_report_t r;
    logic         il;
    logic [4:0]   max_sc;
    logic [4:0]   cur_start;
    logic [4:0]   cur_end;
    logic [6:0]   old_row;
    il        = (regs.row_mode[6:5] == cvts_pkg::IL_FULL);
    max_sc    = regs.row_mode[4:0];
    cur_start = regs.cursor_rows[4:0];
    cur_end   = regs.cursor_rows[12:8];
    r         = '0;
    if (adv) begin
      if (!tm.half_phase) begin
        // first half: retrace starts, address steps one displayed line
        tm.status_reg[0] = 1'b1;
        tm.half_phase    = 1'b1;
        if (tm.disp_on)
          tm.run_address = tm.run_address + 16'(regs.horiz_displayed);
        if (tm.char_row == regs.vsync_row && tm.scan_count == 5'd0)
          tm.status_reg[3] = 1'b1;
        if (int'(tm.line_count) + 1 >= LINE_WRAP)
          tm.line_count = '0;
        else
          tm.line_count = tm.line_count + 9'd1;
      end else begin
        if (tm.disp_on)
          tm.status_reg[0] = 1'b0;
        tm.half_phase = 1'b0;
        if (tm.vsync_left != 5'd0) begin
          tm.vsync_left = tm.vsync_left - 5'd1;
          if (tm.vsync_left == 5'd0)
            tm.status_reg[3] = 1'b0;
        end
        if (scan_hit(tm.scan_count, cur_end, il))
          tm.cursor_line = 1'b0;
        if (tm.adjust_left != 5'd0) begin
          // vertical adjust lines: no row change, address held at row base
          tm.scan_count  = tm.scan_count + 5'd1;
          tm.run_address = tm.row_base;
          tm.adjust_left = tm.adjust_left - 5'd1;
          if (tm.adjust_left == 5'd0) begin
            load_frame_top();
            tm.scan_count = 5'd0;
          end
        end else if (scan_hit(tm.scan_count, max_sc, il)) begin
          // end of character row
          old_row       = tm.char_row;
          tm.row_base   = tm.run_address;
          tm.scan_count = 5'd0;
          tm.char_row   = tm.char_row + 7'd1;
          if (tm.char_row == regs.vert_displayed)
            tm.disp_on = 1'b0;
          if (old_row == regs.vert_total) begin
            tm.char_row    = 7'd0;
            tm.adjust_left = regs.vert_adjust;
            if (tm.adjust_left == 5'd0)
              load_frame_top();
            tm.cursor_allowed = (regs.cursor_rows[6:5] == cvts_pkg::BLINK_OFF) ? 1'b0 :
                                tm.blink_count[4];
          end
          if (tm.char_row == regs.vsync_row) begin
            tm.disp_on     = 1'b0;
            tm.line_count  = '0;
            tm.vsync_left  = 5'(VSYNC_LINES);
            r.frame        = (regs.vsync_row != 7'd0);
            tm.blink_count = tm.blink_count + 5'd1;
          end
        end else begin
          tm.scan_count  = tm.scan_count + 5'd1;
          tm.run_address = tm.row_base;
        end
        if (scan_hit(tm.scan_count, cur_start, il))
          tm.cursor_line = 1'b1;
      end
    end
    r.status  = tm.status_reg;
    r.disp_en = tm.disp_on;
    r.row     = tm.scan_count;
    r.mem     = tm.run_address;
    r.cursor  = tm.cursor_line & tm.cursor_allowed;
    r.blink   = tm.blink_count[4];
    r.line_no = tm.line_count;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      note_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                              results_checked, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feeds tick_plan onto the request side, with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (tick_plan.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {{(cvts_pkg::IN_TDATA_W-1){1'b0}}, tick_plan.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks the result side first, then predicts any tick taken at this
  // edge; a prediction never races its own result since the DUT registers it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    scan_report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_scans.size() == 0) begin
          note_mismatch($sformatf("result with nothing expected, data 0x%0h", m_tdata));
        end else begin
          want = expected_scans.pop_front();
          check_field("status_bits",    m_tdata[cvts_pkg::OB_STATUS_LO +: 4], want.status);
          check_field("display_enable", m_tdata[cvts_pkg::OB_DISP_EN],        want.disp_en);
          check_field("row_address",    m_tdata[cvts_pkg::OB_ROW_LO +: 5],    want.row);
          check_field("memory_address", m_tdata[cvts_pkg::OB_MEM_LO +: 16],   want.mem);
          check_field("cursor_visible", m_tdata[cvts_pkg::OB_CURSOR],         want.cursor);
          check_field("blink_phase",    m_tdata[cvts_pkg::OB_BLINK],          want.blink);
          check_field("frame_done",     m_tdata[cvts_pkg::OB_FRAME],          want.frame);
          check_field("line_number",    m_tdata[cvts_pkg::OB_LINE_LO +: 9],   want.line_no);
          results_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        want = advance_timing(s_tdata[0]);
        if (want.frame)
          frames_predicted++;
        expected_scans.push_back(want);
      end
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_scans.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic write_reg(input cvts_pkg::cfg_idx_t idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= cvts_pkg::CFG_DATA_W'(val);
  endtask

  // writes the whole register file; only called with the block idle
  task automatic program_regs(input cvts_pkg::cfg_t c);
    write_reg(cvts_pkg::REG_HORIZ_DISPLAYED, c.horiz_displayed);
    write_reg(cvts_pkg::REG_VERT_TOTAL,      c.vert_total);
    write_reg(cvts_pkg::REG_VERT_ADJUST,     c.vert_adjust);
    write_reg(cvts_pkg::REG_VERT_DISPLAYED,  c.vert_displayed);
    write_reg(cvts_pkg::REG_VSYNC_ROW,       c.vsync_row);
    write_reg(cvts_pkg::REG_ROW_MODE,        c.row_mode);
    write_reg(cvts_pkg::REG_CURSOR_ROWS,     c.cursor_rows);
    write_reg(cvts_pkg::REG_START_ADDRESS,   c.start_address);
    @(posedge clk);
    cfg_we <= 1'b0;
    regs = c;
    settings_used++;
  endtask

  // queue n ticks, each advancing with the given percentage
  task automatic push_ticks(input int n, input int adv_pct);
    @(negedge clk);
    repeat (n) tick_plan.push_back($urandom_range(99) < adv_pct);
  endtask

  // hold the sender off until every expected result has come back
  task automatic drain_all();
    do @(negedge clk);
    while (tick_plan.size() != 0 || s_tvalid || expected_scans.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // short frames so the random part runs through many frame ends; far_vsync puts
  // the sync row out of reach so the line counter has to wrap on its own
  function automatic cvts_pkg::cfg_t pick_timing(input bit far_vsync);
    cvts_pkg::cfg_t c;
    c.horiz_displayed = 8'($urandom);
    c.vert_total      = 7'($urandom_range(4));
    c.vert_adjust     = 5'($urandom_range(3));
    c.vert_displayed  = 7'($urandom_range(c.vert_total + 1));
    c.vsync_row       = far_vsync ? 7'($urandom_range(127, 100)) :
                                    7'($urandom_range(c.vert_total + 1));
    c.row_mode        = {2'($urandom), 5'($urandom_range(2))};
    // end row, unused bit, blink mode, start row
    c.cursor_rows     = {5'($urandom_range(3)), 1'($urandom), 2'($urandom),
                         5'($urandom_range(3))};
    c.start_address   = 14'($urandom);
    return c;
  endfunction

  initial begin
    cvts_pkg::cfg_t c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // all registers zero: every row end is a frame end with vsync at row zero,
    // so sync and blink run but frame_done must stay low; includes report-only
    program_regs('0);
    tick_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
    drain_all();

    // every register at its top value
    program_regs('1);
    push_ticks(6, 100);
    @(negedge clk);
    tick_plan.push_back(1'b0);
    drain_all();

    // two-row frame with adjust lines, full interlace, cursor blink disabled,
    // start address at its top so the address runs past 14 bits
    c.horiz_displayed = 8'hFF;
    c.vert_total      = 7'd1;
    c.vert_adjust     = 5'd2;
    c.vert_displayed  = 7'd1;
    c.vsync_row       = 7'd1;
    c.row_mode        = {cvts_pkg::IL_FULL, 5'd1};
    c.cursor_rows     = {5'd1, 1'b0, cvts_pkg::BLINK_OFF, 5'd0};
    c.start_address   = cvts_pkg::START_MASK;
    program_regs(c);
    push_ticks(10, 100);
    drain_all();

    // random settings; each phase pauses halfway until all results are back
    for (int ph = 0; ph < 5; ph++) begin
      program_regs(pick_timing(1'b0));
      calm = (ph == 2);
      push_ticks(50, 90);
      drain_all();
      push_ticks(50, 90);
      drain_all();
      calm = 1'b0;
    end

    // long run with sync out of reach: line counter wraps at LINE_WRAP
    program_regs(pick_timing(1'b1));
    push_ticks(400, 96);
    drain_all();
    push_ticks(400, 96);
    drain_all();

    repeat (10) @(negedge clk);
    $display("Run covered %0d results over %0d register settings, %0d frame ends",
             results_checked, settings_used, frames_predicted);
    $display("including report-only ticks, interlace, blink modes and line wrap");
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cvts_pkg.sv
rtl/core/cvts_cfg_regs.sv
rtl/core/cvts_timing.sv
rtl/core/cvts_out_buf.sv
rtl/core/crtc_vertical_timing_sequencer_core.sv
rtl/core/cvts_checker.sv
sim/testbench.sv
